/* hw/rtl/assert_macros.svh */
// Assertion macros included by the deframer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define GPRD_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property must never hold at a clock edge outside reset.
`define GPRD_NEVER(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

/* hw/rtl/gprd_pkg.sv */
// Package with constants, types and the port record decoder of the report deframer.
`timescale 1ns / 1ps

package gprd_pkg;

    localparam int NUM_PORTS  = 4;
    localparam int RECORD_LEN = 9;
    localparam int REPORT_LEN = 1 + RECORD_LEN * NUM_PORTS;
    localparam int OFF_W      = $clog2(RECORD_LEN);
    localparam int PORT_W     = 2;
    localparam int COUNT_W    = 6;

    localparam logic [7:0]         HEADER_BYTE    = 8'h21;
    localparam logic [7:0]         STICK_CENTER   = 8'd128;
    localparam logic [7:0]         TICKS_MAX      = 8'hff;
    localparam logic [7:0]         INTERVAL_RESET = 8'd8;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef logic [RECORD_LEN-1:0][7:0] record_t;

    typedef struct packed {
        logic        connected;
        logic [12:0] buttons;
        logic [7:0]  main_x;
        logic [7:0]  main_y;
        logic [7:0]  c_x;
        logic [7:0]  c_y;
        logic [7:0]  trig_left;
        logic [7:0]  trig_right;
    } port_state_t;

    // One report byte handed from the input stage to the record store.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
        logic       ok;
    } byte_beat_t;

    function automatic port_state_t decode_port(record_t r);
        port_state_t s;
        s = '0;
        if (r[0][7:4] == 4'd0)
        begin
            s.main_x = STICK_CENTER;
            s.main_y = STICK_CENTER;
            s.c_x    = STICK_CENTER;
            s.c_y    = STICK_CENTER;
        end
        else
        begin
            s.connected  = 1'b1;
            s.buttons    = {r[2][0], r[1][3:0], 1'b0, r[2][3:1], r[1][7:4]};
            s.main_x     = r[3];
            s.main_y     = r[4];
            s.c_x        = r[5];
            s.c_y        = r[6];
            s.trig_left  = r[7];
            s.trig_right = r[8];
        end
        return s;
    endfunction

endpackage

/* hw/rtl/gprd_record_store.sv */
// Byte counter, header check and per-port record registers with snapshot decode.
`timescale 1ns / 1ps

module gprd_record_store
    import gprd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  byte_beat_t  beat,
    output logic        report_good,
    output port_state_t snap [NUM_PORTS]
);

    localparam logic [COUNT_W-1:0] LAST_POS = COUNT_W'(REPORT_LEN - 1);
    localparam logic [OFF_W-1:0]   OFF_LAST = OFF_W'(RECORD_LEN - 1);

    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic               header_good_reg, header_good_next;
    logic [PORT_W-1:0]  port_sel_reg, port_sel_next;
    logic [OFF_W-1:0]   off_sel_reg, off_sel_next;
    record_t            rec_reg [NUM_PORTS];
    record_t            rec_view [NUM_PORTS];
    logic               wr_en;

    // Positions 1 through REPORT_LEN-1 carry record bytes; the header is not stored.
    assign wr_en = beat.valid && (byte_count_reg != '0) && (byte_count_reg <= LAST_POS);

    always_comb
    begin
        byte_count_next  = byte_count_reg;
        header_good_next = header_good_reg;
        port_sel_next    = port_sel_reg;
        off_sel_next     = off_sel_reg;
        if (beat.valid)
        begin
            if (byte_count_reg == '0)
            begin
                header_good_next = (beat.data == HEADER_BYTE);
            end
            if (wr_en)
            begin
                if (off_sel_reg == OFF_LAST)
                begin
                    off_sel_next  = '0;
                    port_sel_next = port_sel_reg + PORT_W'(1);
                end
                else
                begin
                    off_sel_next = off_sel_reg + OFF_W'(1);
                end
            end
            if (beat.last)
            begin
                byte_count_next = '0;
                port_sel_next   = '0;
                off_sel_next    = '0;
            end
            else if (byte_count_reg != COUNT_MAX)
            begin
                byte_count_next = byte_count_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            header_good_reg <= 1'b0;
            port_sel_reg    <= '0;
            off_sel_reg     <= '0;
        end
        else
        begin
            byte_count_reg  <= byte_count_next;
            header_good_reg <= header_good_next;
            port_sel_reg    <= port_sel_next;
            off_sel_reg     <= off_sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rec_reg[port_sel_reg][off_sel_reg] <= beat.data;
        end
    end

    // The final byte is still in flight when the report closes, so it is forwarded.
    always_comb
    begin
        for (int p = 0; p < NUM_PORTS; p++)
        begin
            rec_view[p] = rec_reg[p];
            if (wr_en && (port_sel_reg == PORT_W'(p)))
            begin
                rec_view[p][off_sel_reg] = beat.data;
            end
            snap[p] = decode_port(rec_view[p]);
        end
    end

    assign report_good = beat.valid && beat.last && beat.ok &&
                         (byte_count_reg == LAST_POS) && header_good_reg;

endmodule

/* hw/rtl/gamepad_report_deframer.sv */
// Top level of the gamepad report deframer: input stage, emit decision and result output.
//
//   channel   signals                                   direction
//   input     in_valid/in_ready, req_type..transfer_ok  in
//   config    cfg_we, cfg_wdata (emit interval)         in
//   output    out_valid/out_ready, seq..last_port       out
//
// Each input beat passes through one input register and is finished in the next cycle
// unless it waits there, so one beat is taken per cycle while none waits. A snapshot
// leaves as four beats, one per cycle while out_ready is high, from the snapshot register
// through the output register. Only a closing report byte waits, while a prior snapshot
// is still being sent. Reset is asynchronous and active low; record bytes are not reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gamepad_report_deframer
    import gprd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [7:0]  report_byte,
    input  logic        byte_last,
    input  logic        transfer_ok,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] seq,
    output logic [1:0]  port_index,
    output logic        connected,
    output logic [12:0] buttons,
    output logic [7:0]  main_x,
    output logic [7:0]  main_y,
    output logic [7:0]  c_x,
    output logic [7:0]  c_y,
    output logic [7:0]  trig_left,
    output logic [7:0]  trig_right,
    output logic        last_port
);

    localparam logic [PORT_W-1:0] PORT_LAST = PORT_W'(NUM_PORTS - 1);

    // Input register
    logic        in_vld_reg;
    logic        req_type_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic        ok_reg;
    logic        go;
    logic        in_take;

    // Emit state
    logic [7:0]        interval_reg;
    logic [7:0]        ticks_reg, ticks_next;
    logic [31:0]       seq_counter_reg;
    logic [31:0]       emit_seq_reg;
    port_state_t       snap_reg [NUM_PORTS];
    logic              emit_act_reg;
    logic [PORT_W-1:0] emit_idx_reg;
    logic              emit_fire;
    logic              changed;
    logic              report_good;
    port_state_t       snap [NUM_PORTS];
    byte_beat_t        beat;
    logic              out_load;

    // Output register
    logic        out_vld_reg;
    logic [31:0] seq_reg;
    logic [1:0]  port_index_reg;
    port_state_t out_state_reg;
    logic        last_port_reg;

    assign go       = in_vld_reg && !(req_type_reg == REQ_BYTE && last_reg && emit_act_reg);
    assign in_ready = !in_vld_reg || go;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_type_reg <= req_type;
            byte_reg     <= report_byte;
            last_reg     <= byte_last;
            ok_reg       <= transfer_ok;
        end
    end

    assign beat.valid = go && (req_type_reg == REQ_BYTE);
    assign beat.data  = byte_reg;
    assign beat.last  = last_reg;
    assign beat.ok    = ok_reg;

    gprd_record_store u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .beat        (beat),
        .report_good (report_good),
        .snap        (snap)
    );

    always_comb
    begin
        changed = 1'b0;
        for (int p = 0; p < NUM_PORTS; p++)
        begin
            if (snap[p] != snap_reg[p])
            begin
                changed = 1'b1;
            end
        end
    end

    assign emit_fire = report_good && (changed || (ticks_reg >= interval_reg));

    always_comb
    begin
        ticks_next = ticks_reg;
        if (emit_fire)
        begin
            ticks_next = '0;
        end
        else if (go && (req_type_reg == REQ_TICK) && (ticks_reg != TICKS_MAX))
        begin
            ticks_next = ticks_reg + 8'd1;
        end
    end

    assign out_load = emit_act_reg && (!out_vld_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg    <= INTERVAL_RESET;
            ticks_reg       <= TICKS_MAX;
            seq_counter_reg <= '0;
            emit_seq_reg    <= '0;
            emit_act_reg    <= 1'b0;
            emit_idx_reg    <= '0;
            out_vld_reg     <= 1'b0;
            for (int p = 0; p < NUM_PORTS; p++)
            begin
                snap_reg[p] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                interval_reg <= cfg_wdata;
            end
            ticks_reg <= ticks_next;
            if (emit_fire)
            begin
                for (int p = 0; p < NUM_PORTS; p++)
                begin
                    snap_reg[p] <= snap[p];
                end
                emit_seq_reg    <= seq_counter_reg;
                seq_counter_reg <= seq_counter_reg + 32'd1;
                emit_act_reg    <= 1'b1;
                emit_idx_reg    <= '0;
            end
            else if (out_load)
            begin
                emit_idx_reg <= emit_idx_reg + PORT_W'(1);
                if (emit_idx_reg == PORT_LAST)
                begin
                    emit_act_reg <= 1'b0;
                end
            end
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            seq_reg        <= emit_seq_reg;
            port_index_reg <= emit_idx_reg;
            out_state_reg  <= snap_reg[emit_idx_reg];
            last_port_reg  <= (emit_idx_reg == PORT_LAST);
        end
    end

    assign out_valid  = out_vld_reg;
    assign seq        = seq_reg;
    assign port_index = port_index_reg;
    assign connected  = out_state_reg.connected;
    assign buttons    = out_state_reg.buttons;
    assign main_x     = out_state_reg.main_x;
    assign main_y     = out_state_reg.main_y;
    assign c_x        = out_state_reg.c_x;
    assign c_y        = out_state_reg.c_y;
    assign trig_left  = out_state_reg.trig_left;
    assign trig_right = out_state_reg.trig_right;
    assign last_port  = last_port_reg;

    `GPRD_NEVER(a_no_emit_while_sending, clk, rst_n, emit_fire && emit_act_reg, "snapshot decided while previous one still sending")
    `GPRD_ASSERT(a_seq_advances, clk, rst_n, emit_act_reg |-> (seq_counter_reg == emit_seq_reg + 32'd1), "sequence counter out of step with snapshot in flight")
    `GPRD_ASSERT(a_stall_only_when_sending, clk, rst_n, !in_ready |-> emit_act_reg, "input stalled with no snapshot in flight")

endmodule
